### rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the timer table scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int US_PER_MS = 1000;
    localparam int MUL_C_W   = 11;
    localparam int PROD_W    = 43;

    localparam logic [2:0] OP_REGISTER   = 3'd0;
    localparam logic [2:0] OP_UNREGISTER = 3'd1;
    localparam logic [2:0] OP_EXISTS     = 3'd2;
    localparam logic [2:0] OP_SET_EVENT  = 3'd3;
    localparam logic [2:0] OP_TICK       = 3'd4;

    localparam logic [2:0] KIND_BEFORE   = 3'b111;
    localparam logic [2:0] KIND_ON       = 3'b000;
    localparam logic [2:0] KIND_AFTER    = 3'b001;
    localparam logic [2:0] KIND_PERIODIC = 3'b010;

    localparam logic [1:0] RES_OK    = 2'd0;
    localparam logic [1:0] RES_FAIL  = 2'd1;
    localparam logic [1:0] RES_FIRED = 2'd2;
    localparam logic [1:0] RES_DONE  = 2'd3;

    localparam logic REG_MIN_INTERVAL = 1'b0;
    localparam logic REG_MAX_INTERVAL = 1'b1;

    localparam logic [30:0] MIN_INTERVAL_RST = 31'd1;
    localparam logic [30:0] MAX_INTERVAL_RST = 31'd86400000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_WALK,
        ST_FLUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              capture;
        logic              exec;
        logic              walk;
        logic [SLOT_W-1:0] idx;
        logic              done;
    } t_ctrl;

endpackage

### rtl/timer_table_scheduler.sv
// ----------------------------------------------------------------------------
// timer_table_scheduler
// Table of periodic and one-shot timer slots with command and tick requests.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low. A command
// (register, unregister, exists, set event time or an unknown op) holds
// o_busy high in ST_CMD; its single result passes that state, then the
// result register. A tick walks the slot table one slot per clock through
// a two-stage due-time compare, o_busy high in walk, flush and done states;
// a fire result per due slot comes out in slot order, then the done result.
// Every result is shown for exactly one cycle with o_valid high and must
// be taken then: there is no way to hold results off. Configuration writes
// on i_cfg_we take effect at once and belong to idle periods only.
// ----------------------------------------------------------------------------
module timer_table_scheduler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_op,
    input  logic [3:0]         i_slot,
    input  logic signed [2:0]  i_trigger_kind,
    input  logic signed [31:0] i_interval_ms,
    input  logic signed [63:0] i_event_time_us,
    input  logic signed [31:0] i_offset_ms,
    input  logic [62:0]        i_now_us,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    output logic               o_valid,
    output logic [1:0]         o_result_kind,
    output logic [3:0]         o_fired_slot,
    output logic               o_found,
    output logic               o_last
);

    tts_pkg::t_ctrl ctrl;

    tts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_op),
        .o_busy  (o_busy),
        .o_ctrl  (ctrl)
    );

    tts_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_slot          (i_slot),
        .i_trigger_kind  (i_trigger_kind),
        .i_interval_ms   (i_interval_ms),
        .i_event_time_us (i_event_time_us),
        .i_offset_ms     (i_offset_ms),
        .i_now_us        (i_now_us),
        .o_valid         (o_valid),
        .o_result_kind   (o_result_kind),
        .o_fired_slot    (o_fired_slot),
        .o_found         (o_found),
        .o_last          (o_last)
    );

endmodule

### rtl/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer: accepts requests, runs a command cycle or the slot walk of a tick.
// ----------------------------------------------------------------------------
module tts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2:0]     i_op,
    output logic           o_busy,
    output tts_pkg::t_ctrl o_ctrl
);

    tts_pkg::t_state r_state, n_state;
    logic [tts_pkg::SLOT_W-1:0] r_idx, n_idx;
    logic walk_end;

    assign walk_end = (r_idx == tts_pkg::SLOT_W'(tts_pkg::SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tts_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tts_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_op == tts_pkg::OP_TICK) ? tts_pkg::ST_WALK : tts_pkg::ST_CMD;
                end
            end
            tts_pkg::ST_CMD:   n_state = tts_pkg::ST_IDLE;
            tts_pkg::ST_WALK: begin
                if (walk_end) begin
                    n_state = tts_pkg::ST_FLUSH;
                end
            end
            tts_pkg::ST_FLUSH: n_state = tts_pkg::ST_DONE;
            tts_pkg::ST_DONE:  n_state = tts_pkg::ST_IDLE;
            default:           n_state = tts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy         = 1'b1;
        o_ctrl.capture = 1'b0;
        o_ctrl.exec    = 1'b0;
        o_ctrl.walk    = 1'b0;
        o_ctrl.done    = 1'b0;
        o_ctrl.idx     = r_idx;
        n_idx          = r_idx;
        case (r_state)
            tts_pkg::ST_IDLE: begin
                o_busy         = 1'b0;
                o_ctrl.capture = i_start;
                n_idx          = '0;
            end
            tts_pkg::ST_CMD:   o_ctrl.exec = 1'b1;
            tts_pkg::ST_WALK: begin
                o_ctrl.walk = 1'b1;
                n_idx       = r_idx + 1'b1;
            end
            tts_pkg::ST_FLUSH: o_busy = 1'b1;
            tts_pkg::ST_DONE:  o_ctrl.done = 1'b1;
            default:           o_busy = 1'b1;
        endcase
    end

endmodule

### rtl/tts_dp.sv
// ----------------------------------------------------------------------------
// tts_dp
// Slot table, command execution, two-stage due-time compare and result register.
// ----------------------------------------------------------------------------
module tts_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tts_pkg::t_ctrl     i_ctrl,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic [2:0]         i_op,
    input  logic [3:0]         i_slot,
    input  logic signed [2:0]  i_trigger_kind,
    input  logic signed [31:0] i_interval_ms,
    input  logic signed [63:0] i_event_time_us,
    input  logic signed [31:0] i_offset_ms,
    input  logic [62:0]        i_now_us,
    output logic               o_valid,
    output logic [1:0]         o_result_kind,
    output logic [3:0]         o_fired_slot,
    output logic               o_found,
    output logic               o_last
);

    // configuration
    logic [30:0] r_min_ms, r_max_ms;

    // captured request
    logic [2:0]         r_op;
    logic [3:0]         r_slot;
    logic [2:0]         r_kind;
    logic signed [31:0] r_interval;
    logic signed [63:0] r_event;
    logic signed [31:0] r_offset;
    logic [62:0]        r_now;

    // slot table
    logic               r_valid [tts_pkg::SLOTS];
    logic [2:0]         r_skind [tts_pkg::SLOTS];
    logic [30:0]        r_sint  [tts_pkg::SLOTS];
    logic [62:0]        r_sevt  [tts_pkg::SLOTS];
    logic signed [31:0] r_soff  [tts_pkg::SLOTS];
    logic [62:0]        r_slast [tts_pkg::SLOTS];
    logic               r_sfired[tts_pkg::SLOTS];

    // walk pipeline
    logic                        r_s1_vld;
    logic                        r_s1_elig;
    logic                        r_s1_per;
    logic [tts_pkg::SLOT_W-1:0]  r_s1_idx;
    logic [62:0]                 r_s1_base;
    logic signed [tts_pkg::PROD_W-1:0] r_s1_prod;

    // result register
    logic       r_out_vld, n_out_vld;
    logic [1:0] r_out_kind, n_out_kind;
    logic [3:0] r_out_slot, n_out_slot;
    logic       r_out_found, n_out_found;
    logic       r_out_last, n_out_last;

    logic [tts_pkg::SLOT_W-1:0] cmd_idx, rd_idx;
    logic        in_range, cmd_valid, kind_ok;
    logic        rd_valid, rd_per;
    logic [2:0]  rd_kind;
    logic [1:0]  cmd_res;
    logic        cmd_found;
    logic        reg_we, unreg_we, set_we;

    logic [31:0] int_mag;
    logic [30:0] int_clamped;
    logic [63:0] evt_mag;
    logic [62:0] evt_sat;
    logic [31:0] off_mag;
    logic signed [31:0] off_sat;

    logic signed [31:0]                 mul_a;
    logic signed [tts_pkg::MUL_C_W-1:0] mul_c;
    logic signed [tts_pkg::PROD_W-1:0]  s1_prod;

    logic signed [64:0] s2_due, s2_now;
    logic               s2_fire;

    assign cmd_idx  = r_slot[tts_pkg::SLOT_W-1:0];
    assign in_range = (32'(r_slot) < 32'(tts_pkg::SLOTS));
    assign rd_idx   = i_ctrl.walk ? i_ctrl.idx : cmd_idx;
    assign rd_valid = r_valid[rd_idx];
    assign rd_kind  = r_skind[rd_idx];
    assign rd_per   = (rd_kind == tts_pkg::KIND_PERIODIC);
    assign cmd_valid = in_range && rd_valid;
    assign kind_ok  = r_kind inside {tts_pkg::KIND_BEFORE, tts_pkg::KIND_ON,
                                     tts_pkg::KIND_AFTER, tts_pkg::KIND_PERIODIC};

    // magnitudes, saturation and clamp
    assign int_mag = r_interval[31] ? 32'(-r_interval) : 32'(r_interval);
    assign evt_mag = r_event[63] ? 64'(-r_event) : 64'(r_event);
    assign evt_sat = evt_mag[63] ? {63{1'b1}} : evt_mag[62:0];
    assign off_mag = r_offset[31] ? 32'(-r_offset) : 32'(r_offset);
    assign off_sat = off_mag[31] ? 32'sh7FFF_FFFF : $signed(off_mag);

    always_comb begin
        if (int_mag < {1'b0, r_min_ms}) begin
            int_clamped = r_min_ms;
        end else if (int_mag > {1'b0, r_max_ms}) begin
            int_clamped = r_max_ms;
        end else begin
            int_clamped = int_mag[30:0];
        end
    end

    always_comb begin
        cmd_res   = tts_pkg::RES_FAIL;
        cmd_found = 1'b0;
        reg_we    = 1'b0;
        unreg_we  = 1'b0;
        set_we    = 1'b0;
        case (r_op)
            tts_pkg::OP_REGISTER: begin
                if (cmd_valid) begin
                    cmd_res = tts_pkg::RES_OK;
                end else if (in_range && kind_ok) begin
                    cmd_res = tts_pkg::RES_OK;
                    reg_we  = i_ctrl.exec;
                end
            end
            tts_pkg::OP_UNREGISTER: begin
                if (cmd_valid) begin
                    cmd_res  = tts_pkg::RES_OK;
                    unreg_we = i_ctrl.exec;
                end
            end
            tts_pkg::OP_EXISTS: begin
                cmd_res   = tts_pkg::RES_OK;
                cmd_found = cmd_valid;
            end
            tts_pkg::OP_SET_EVENT: begin
                if (cmd_valid && !rd_per) begin
                    cmd_res = tts_pkg::RES_OK;
                    set_we  = i_ctrl.exec;
                end
            end
            default: cmd_res = tts_pkg::RES_FAIL;
        endcase
    end

    // one multiplier for both slot kinds: interval*1000 or kind*offset*1000
    always_comb begin
        if (rd_per) begin
            mul_a = $signed({1'b0, r_sint[rd_idx]});
            mul_c = tts_pkg::MUL_C_W'(tts_pkg::US_PER_MS);
        end else begin
            mul_a = r_soff[rd_idx];
            case (rd_kind)
                tts_pkg::KIND_BEFORE: mul_c = -tts_pkg::MUL_C_W'(tts_pkg::US_PER_MS);
                tts_pkg::KIND_AFTER:  mul_c = tts_pkg::MUL_C_W'(tts_pkg::US_PER_MS);
                default:              mul_c = '0;
            endcase
        end
    end

    assign s1_prod = mul_a * mul_c;

    assign s2_due  = $signed({2'b00, r_s1_base})
                   + {{(65 - tts_pkg::PROD_W){r_s1_prod[tts_pkg::PROD_W-1]}}, r_s1_prod};
    assign s2_now  = $signed({2'b00, r_now});
    assign s2_fire = r_s1_vld && r_s1_elig && (s2_now >= s2_due);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ms <= tts_pkg::MIN_INTERVAL_RST;
            r_max_ms <= tts_pkg::MAX_INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tts_pkg::REG_MIN_INTERVAL: r_min_ms <= i_cfg_data;
                tts_pkg::REG_MAX_INTERVAL: r_max_ms <= i_cfg_data;
                default:                   r_min_ms <= r_min_ms;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_op       <= i_op;
            r_slot     <= i_slot;
            r_kind     <= i_trigger_kind;
            r_interval <= i_interval_ms;
            r_event    <= i_event_time_us;
            r_offset   <= i_offset_ms;
            r_now      <= i_now_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < tts_pkg::SLOTS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (reg_we) begin
            r_valid[cmd_idx] <= 1'b1;
        end else if (unreg_we) begin
            r_valid[cmd_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            r_skind[cmd_idx]  <= r_kind;
            r_slast[cmd_idx]  <= '0;
            r_sfired[cmd_idx] <= 1'b0;
            if (r_kind == tts_pkg::KIND_PERIODIC) begin
                r_sint[cmd_idx] <= int_clamped;
            end else begin
                r_sevt[cmd_idx] <= evt_sat;
                r_soff[cmd_idx] <= r_offset;
            end
        end
        if (set_we) begin
            r_sevt[cmd_idx] <= evt_sat;
            r_soff[cmd_idx] <= off_sat;
        end
        if (s2_fire) begin
            if (r_s1_per) begin
                r_slast[r_s1_idx] <= r_now;
            end else begin
                r_sfired[r_s1_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctrl.walk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= i_ctrl.idx;
        r_s1_per  <= rd_per;
        r_s1_elig <= rd_valid && (rd_per || !r_sfired[rd_idx]);
        r_s1_base <= rd_per ? r_slast[rd_idx] : r_sevt[rd_idx];
        r_s1_prod <= s1_prod;
    end

    always_comb begin
        n_out_vld   = 1'b0;
        n_out_kind  = tts_pkg::RES_OK;
        n_out_slot  = '0;
        n_out_found = 1'b0;
        n_out_last  = 1'b1;
        if (i_ctrl.exec) begin
            n_out_vld   = 1'b1;
            n_out_kind  = cmd_res;
            n_out_found = cmd_found;
        end else if (s2_fire) begin
            n_out_vld  = 1'b1;
            n_out_kind = tts_pkg::RES_FIRED;
            n_out_slot = 4'(r_s1_idx);
            n_out_last = 1'b0;
        end else if (i_ctrl.done) begin
            n_out_vld  = 1'b1;
            n_out_kind = tts_pkg::RES_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

    assign o_valid       = r_out_vld;
    assign o_result_kind = r_out_kind;
    assign o_fired_slot  = r_out_slot;
    assign o_found       = r_out_found;
    assign o_last        = r_out_last;

endmodule
